// File: hw/rtl/emrld_pkg.sv
// ----------------------------------------------------------------------------
// emrld_pkg: shared types and constants of the escape-marker run-length decoder
// Holds the marker codes, the front parser phases and the command format
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package emrld_pkg;

  // Marker pair, count field and repeat flag of a record's control byte.
  localparam logic [7:0] MarkFirst  = 8'h60;
  localparam logic [7:0] MarkSecond = 8'h7c;
  localparam int         CountW     = 5;
  localparam int         RepeatBit  = 6;

  // Front parser phases.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PEND = 4'b0010,
    PH_CTRL = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  // One command for the back part: an optional leading 0x60, count copies
  // of data, an optional trailing 0x60, and the end-of-stream flag.
  typedef struct packed {
    logic              pre;
    logic [7:0]        data;
    logic [CountW-1:0] count;
    logic              post;
    logic              last;
  } cmd_t;

endpackage

// File: hw/rtl/emrld_stream_if.sv
// ----------------------------------------------------------------------------
// emrld_stream_if: byte channels of the decoder
// Input channel carries encoded bytes, output channel restored bytes.
// ----------------------------------------------------------------------------
interface emrld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface emrld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

// File: hw/rtl/escape_marker_run_length_decoder.sv
// A beat's first result passes a queue entry, then the command registers.
// Throughput: one input beat per cycle; a command emits one output beat per cycle
// while out ready is high, so a repeat record of count n holds the output for n
// beats; the input stalls once the queue (FifoDepth entries) fills behind it.
// Reset: rst_ni clears parser phase, queue pointers and expander busy flag at once.
// ----------------------------------------------------------------------------
// escape_marker_run_length_decoder: top level
// Parser front part, command queue and expander back part.
// ----------------------------------------------------------------------------
module escape_marker_run_length_decoder #(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  emrld_in_if.sink    in_i,
  emrld_out_if.source out_o
);
  import emrld_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty;

  emrld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_full_i (full),
    .cmd_push_o (push),
    .cmd_o      (push_cmd)
  );

  emrld_cmd_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  emrld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

// File: hw/rtl/emrld_front.sv
// ----------------------------------------------------------------------------
// emrld_front: marker parser
// Accepts one encoded byte per beat, tracks the marker and record phases and
// turns each byte into a command for the back part.
// ----------------------------------------------------------------------------
module emrld_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  emrld_in_if.sink          in_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output emrld_pkg::cmd_t   cmd_o
);
  import emrld_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              rep_q, rep_d;
  logic              accept;
  logic [CountW-1:0] cnt_dec;
  cmd_t              cmd;

  assign in_i.ready = ~cmd_full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign cnt_dec    = cnt_q - CountW'(1);

  // Classify the byte against the current phase.
  always_comb begin
    cmd     = '0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rep_d   = rep_q;
    unique case (phase_q)
      PH_PEND: begin
        if (in_i.in_byte == MarkSecond) begin
          phase_d = PH_CTRL;
        end else begin
          cmd.pre = 1'b1;
          if (in_i.in_byte == MarkFirst) begin
            phase_d = PH_PEND;
          end else begin
            cmd.count = CountW'(1);
            cmd.data  = in_i.in_byte;
            phase_d   = PH_IDLE;
          end
        end
      end
      PH_CTRL: begin
        cnt_d = in_i.in_byte[CountW-1:0];
        rep_d = in_i.in_byte[RepeatBit];
        if (!in_i.in_byte[RepeatBit] && in_i.in_byte[CountW-1:0] == '0) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        cmd.data = in_i.in_byte;
        if (rep_q) begin
          cmd.count = cnt_q;
          cnt_d     = '0;
          phase_d   = PH_IDLE;
        end else begin
          cmd.count = CountW'(1);
          cnt_d     = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
        if (in_i.in_byte == MarkFirst) begin
          phase_d = PH_PEND;
        end else begin
          cmd.count = CountW'(1);
          cmd.data  = in_i.in_byte;
          phase_d   = PH_IDLE;
        end
      end
    endcase

    // End of stream flushes a pending marker and drops an open record.
    if (in_i.in_last) begin
      cmd.post = (phase_d == PH_PEND);
      cmd.last = 1'b1;
      phase_d  = PH_IDLE;
      cnt_d    = '0;
      rep_d    = 1'b0;
    end
  end

  // Only commands that produce at least one result enter the queue.
  assign cmd_o      = cmd;
  assign cmd_push_o = accept & (cmd.pre | (cmd.count != '0) | cmd.post | cmd.last);

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      rep_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// File: hw/rtl/emrld_cmd_fifo.sv
// ----------------------------------------------------------------------------
// emrld_cmd_fifo: command queue
// Short queue between parser and expander so that each side stalls alone.
// ----------------------------------------------------------------------------
module emrld_cmd_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  emrld_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output emrld_pkg::cmd_t pop_data_o,
  output logic            empty_o
);
  import emrld_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == CntW'(Depth));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// File: hw/rtl/emrld_back.sv
// ----------------------------------------------------------------------------
// emrld_back: command expander
// Holds one command and emits its bytes, one output beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module emrld_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  emrld_pkg::cmd_t cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  emrld_out_if.source     out_o
);
  import emrld_pkg::*;

  logic              busy_q;
  logic              pre_q, post_q, last_q;
  logic [CountW-1:0] cnt_q;
  logic [7:0]        data_q;
  logic              has_cnt, more, fire, done;

  assign has_cnt = (cnt_q != '0);

  // Whether any result remains after the one on the output.
  always_comb begin
    if (pre_q) begin
      more = has_cnt | post_q;
    end else if (has_cnt) begin
      more = (cnt_q != CountW'(1)) | post_q;
    end else begin
      more = 1'b0;
    end
  end

  // Output beat straight from the command registers.
  assign out_o.valid     = busy_q;
  assign out_o.out_valid = pre_q | has_cnt | post_q;
  assign out_o.out_byte  = pre_q   ? MarkFirst :
                           has_cnt ? data_q    :
                           post_q  ? MarkFirst : 8'h00;
  assign out_o.out_last  = last_q & ~more;

  assign fire      = out_o.valid & out_o.ready;
  assign done      = fire & ~more;
  assign cmd_pop_o = ~cmd_empty_i & (~busy_q | done);

  // Busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  // Current command: load a new one or step through the held one.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      pre_q  <= cmd_i.pre;
      cnt_q  <= cmd_i.count;
      post_q <= cmd_i.post;
      data_q <= cmd_i.data;
      last_q <= cmd_i.last;
    end else if (fire) begin
      if (pre_q) begin
        pre_q <= 1'b0;
      end else if (has_cnt) begin
        cnt_q <= cnt_q - CountW'(1);
      end else begin
        post_q <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/emrld_checker.sv
// ----------------------------------------------------------------------------
// emrld_checker: port-level checks of the decoder
// Watches the output channel and is bound to the top level.
// ----------------------------------------------------------------------------
module emrld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_vld_i,
  input logic       out_rdy_i,
  input logic [7:0] out_byte_i,
  input logic       out_valid_i,
  input logic       out_last_i
);

  // A stalled output beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_rdy_i |=> out_vld_i && $stable(out_byte_i) &&
      $stable(out_valid_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  // An empty item only marks the end of a stream.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_valid_i |-> out_last_i)
    else $error("empty item without end of stream");

  // An empty item carries a zero byte.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_valid_i |-> out_byte_i == 8'h00)
    else $error("empty item with nonzero byte");

endmodule

bind escape_marker_run_length_decoder emrld_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_vld_i   (out_o.valid),
  .out_rdy_i   (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_valid_i (out_o.out_valid),
  .out_last_i  (out_o.out_last)
);
